// ===== src/assert_macros.svh =====
// Assertion macros shared by the lidar return calibration RTL.
// Define NO_ASSERTIONS to compile every assertion macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LRP_ASSERT_MSG(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);
`define LRP_ASSERT(label, clk, rstn, prop) \
    `LRP_ASSERT_MSG(label, clk, rstn, prop, "lidar return block: assertion failed")
`else
`define LRP_ASSERT_MSG(label, clk, rstn, prop, msg)
`define LRP_ASSERT(label, clk, rstn, prop)
`endif
`endif

// ===== src/lrp_pkg.sv =====
// Shared types and constants for the lidar return to polar point block.
// No dependencies; every module of the block imports this package.
`default_nettype none

package lrp_pkg;

    // Fixed field widths.
    localparam int HEADER_W    = 16;
    localparam int SLOT_W      = 5;
    localparam int ROT_W       = 16;
    localparam int RAW_W       = 16;
    localparam int INTEN_W     = 8;
    localparam int CAL_IDX_W   = 6;
    localparam int CAL_DIST_W  = 16;
    localparam int CAL_ROT_W   = 16;
    localparam int CAL_VERT_W  = 15;
    localparam int LASER_OUT_W = 6;
    localparam int RANGE_W     = 18;
    localparam int HEAD_W      = 16;

    // Internal laser number: slot plus at most 64, so below 128.
    localparam int LSUM_W = 7;
    // Heading difference and its offset, non-negative form.
    localparam int DIFF_W = 18;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER_BANK = 2'd0,
        CFG_MIN_RANGE  = 2'd1,
        CFG_MAX_RANGE  = 2'd2
    } cfg_index_t;

    typedef enum logic {
        FUNC_LOAD   = 1'b0,
        FUNC_RETURN = 1'b1
    } func_t;

    localparam logic [HEADER_W-1:0]       LOWER_BANK_RST = 16'd56831;
    localparam logic signed [RANGE_W-1:0] MIN_RANGE_RST  = 18'sd0;
    localparam logic signed [RANGE_W-1:0] MAX_RANGE_RST  = 18'sd65535;

    // One calibration entry per laser.
    typedef struct packed {
        logic signed [CAL_DIST_W-1:0] distance;
        logic signed [CAL_ROT_W-1:0]  rot;
        logic signed [CAL_VERT_W-1:0] vert;
    } cal_entry_t;

endpackage

`default_nettype wire

// ===== src/lidar_return_to_polar_top.sv =====
// Top level of the lidar return to polar point block: input stage,
// calibration memory, heading reduction and result register.
// Depends on lrp_pkg, lrp_cal_tables, lrp_quot_est, lrp_wrap_fix, assert_macros.svh.
//
//   channel   | ports            | direction | moves
//   ----------+------------------+-----------+-----------------------------------
//   input     | s_valid/s_ready  | in        | calibration load or laser return
//   result    | m_valid/m_ready  | out       | one calibrated polar point
//   config    | cfg_wr_en        | in        | register write, no wait state
//
// A transfer is taken in every cycle when the result side keeps up; a return
// is read from the calibration memory at its input transfer, and a kept one
// moves on to stage 2 (quotient estimate), then to the result register
// (remainder and wrap). A load writes the calibration memory at the edge of its
// transfer. Reset is synchronous and active low; it empties the pipeline and
// restores the configuration registers. The calibration memory is not cleared.
// When m_ready is low, each stage holds until the one after it frees up, so
// up to three returns sit in the pipeline before s_ready drops.
`default_nettype none
`include "assert_macros.svh"

module lidar_return_to_polar_top #(
    parameter int LASERS_PER_BANK = 32,
    parameter int NUM_LASERS      = 64,
    parameter int STEPS_PER_TURN  = 36000
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    input  wire logic                                  cfg_wr_en,
    input  wire logic [lrp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [lrp_pkg::CFG_DATA_W-1:0]        cfg_wdata,

    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_func,
    input  wire logic [lrp_pkg::HEADER_W-1:0]          s_bank_header,
    input  wire logic [lrp_pkg::SLOT_W-1:0]            s_slot,
    input  wire logic [lrp_pkg::ROT_W-1:0]             s_rotation,
    input  wire logic [lrp_pkg::RAW_W-1:0]             s_raw_distance,
    input  wire logic [lrp_pkg::INTEN_W-1:0]           s_intensity,
    input  wire logic [lrp_pkg::CAL_IDX_W-1:0]         s_cal_index,
    input  wire logic signed [lrp_pkg::CAL_DIST_W-1:0] s_cal_distance,
    input  wire logic signed [lrp_pkg::CAL_ROT_W-1:0]  s_cal_rotation,
    input  wire logic signed [lrp_pkg::CAL_VERT_W-1:0] s_cal_vertical,

    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [lrp_pkg::LASER_OUT_W-1:0]            m_laser_index,
    output logic signed [lrp_pkg::RANGE_W-1:0]         m_range,
    output logic signed [lrp_pkg::HEAD_W-1:0]          m_heading,
    output logic signed [lrp_pkg::CAL_VERT_W-1:0]      m_pitch,
    output logic [lrp_pkg::INTEN_W-1:0]                m_point_intensity
);
    import lrp_pkg::*;

    localparam int ADDR_W   = (NUM_LASERS > 1) ? $clog2(NUM_LASERS) : 1;
    // Bounds of the wrapped heading, (-turn/2, turn/2].
    localparam int HEAD_MAX = STEPS_PER_TURN / 2;
    localparam int HEAD_MIN = -((STEPS_PER_TURN - 1) / 2);

    // Configuration registers.
    logic [HEADER_W-1:0]       lower_bank_reg;
    logic signed [RANGE_W-1:0] min_range_reg;
    logic signed [RANGE_W-1:0] max_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_bank_reg <= LOWER_BANK_RST;
            min_range_reg  <= MIN_RANGE_RST;
            max_range_reg  <= MAX_RANGE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LOWER_BANK: lower_bank_reg <= cfg_wdata[HEADER_W-1:0];
                CFG_MIN_RANGE:  min_range_reg  <= $signed(cfg_wdata[RANGE_W-1:0]);
                CFG_MAX_RANGE:  max_range_reg  <= $signed(cfg_wdata[RANGE_W-1:0]);
                default: ;
            endcase
        end
    end

    // Input side: laser number and range checks on the incoming item.
    logic              accept;
    logic              is_return;
    logic [LSUM_W-1:0] laser_sum;
    logic              ret_ok;
    logic [LSUM_W-1:0] cal_ext;
    logic              cal_ok;
    logic              tbl_wr_en;
    logic              tbl_rd_en;
    cal_entry_t        tbl_wr_data;
    cal_entry_t        tbl_rd_data;

    // Pipeline control.
    logic p1_valid_reg, p1_valid_next;
    logic p2_valid_reg, p2_valid_next;
    logic m_valid_reg, m_valid_next;
    logic p2_ready;
    logic out_adv;
    logic p1_keep;

    always_comb begin
        accept    = s_valid && s_ready;
        is_return = (func_t'(s_func) == FUNC_RETURN);
        laser_sum = LSUM_W'(s_slot)
                  + ((s_bank_header == lower_bank_reg) ? LSUM_W'(LASERS_PER_BANK) : '0);
        ret_ok    = (LSUM_W'(s_slot) < LSUM_W'(LASERS_PER_BANK))
                 && ({1'b0, laser_sum} < (LSUM_W+1)'(NUM_LASERS));
        cal_ext   = LSUM_W'(s_cal_index);
        cal_ok    = ({1'b0, cal_ext} < (LSUM_W+1)'(NUM_LASERS));
        tbl_wr_en = accept && !is_return && cal_ok;
        tbl_rd_en = accept && is_return && ret_ok;
        tbl_wr_data.distance = s_cal_distance;
        tbl_wr_data.rot      = s_cal_rotation;
        tbl_wr_data.vert     = s_cal_vertical;
    end

    lrp_cal_tables #(
        .DEPTH  (NUM_LASERS),
        .ADDR_W (ADDR_W)
    ) u_tables (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (cal_ext[ADDR_W-1:0]),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (laser_sum[ADDR_W-1:0]),
        .rd_data (tbl_rd_data)
    );

    // Stage 1: return fields waiting beside the memory read data.
    logic [LASER_OUT_W-1:0] p1_laser_reg;
    logic [ROT_W-1:0]       p1_rot_reg;
    logic [RAW_W-1:0]       p1_raw_reg;
    logic [INTEN_W-1:0]     p1_inten_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_laser_reg <= laser_sum[LASER_OUT_W-1:0];
            p1_rot_reg   <= s_rotation;
            p1_raw_reg   <= s_raw_distance;
            p1_inten_reg <= s_intensity;
        end
    end

    logic signed [RANGE_W-1:0] p1_range;
    logic signed [DIFF_W-1:0]  p1_diff;
    logic [DIFF_W-1:0]         p1_d_off;
    logic [DIFF_W-1:0]         p1_q_est;

    always_comb begin
        p1_range = $signed({2'b00, p1_raw_reg})
                 + $signed({{(RANGE_W-CAL_DIST_W){tbl_rd_data.distance[CAL_DIST_W-1]}},
                            tbl_rd_data.distance});
        p1_keep  = (p1_range >= min_range_reg) && (p1_range <= max_range_reg);
        p1_diff  = $signed({{(DIFF_W-CAL_ROT_W){tbl_rd_data.rot[CAL_ROT_W-1]}},
                            tbl_rd_data.rot})
                 - $signed({2'b00, p1_rot_reg});
    end

    lrp_quot_est #(
        .STEPS_PER_TURN (STEPS_PER_TURN)
    ) u_quot (
        .diff  (p1_diff),
        .d_off (p1_d_off),
        .q_est (p1_q_est)
    );

    // Stage 2: kept returns with the quotient estimate.
    logic [LASER_OUT_W-1:0]    p2_laser_reg;
    logic signed [RANGE_W-1:0] p2_range_reg;
    logic [DIFF_W-1:0]         p2_d_off_reg;
    logic [DIFF_W-1:0]         p2_q_reg;
    logic signed [CAL_VERT_W-1:0] p2_pitch_reg;
    logic [INTEN_W-1:0]        p2_inten_reg;
    logic signed [DIFF_W-1:0]  p2_heading;

    always_ff @(posedge aclk) begin
        if (p1_valid_reg && p2_ready) begin
            p2_laser_reg <= p1_laser_reg;
            p2_range_reg <= p1_range;
            p2_d_off_reg <= p1_d_off;
            p2_q_reg     <= p1_q_est;
            p2_pitch_reg <= tbl_rd_data.vert;
            p2_inten_reg <= p1_inten_reg;
        end
    end

    lrp_wrap_fix #(
        .STEPS_PER_TURN (STEPS_PER_TURN)
    ) u_wrap (
        .d_off   (p2_d_off_reg),
        .q_est   (p2_q_reg),
        .heading (p2_heading)
    );

    // Result register.
    logic [LASER_OUT_W-1:0]       m_laser_reg;
    logic signed [RANGE_W-1:0]    m_range_reg;
    logic signed [HEAD_W-1:0]     m_heading_reg;
    logic signed [CAL_VERT_W-1:0] m_pitch_reg;
    logic [INTEN_W-1:0]           m_inten_reg;

    always_ff @(posedge aclk) begin
        if (p2_valid_reg && out_adv) begin
            m_laser_reg   <= p2_laser_reg;
            m_range_reg   <= p2_range_reg;
            m_heading_reg <= $signed(p2_heading[HEAD_W-1:0]);
            m_pitch_reg   <= p2_pitch_reg;
            m_inten_reg   <= p2_inten_reg;
        end
    end

    // Each stage moves when the one after it is empty or moving. Loads and returns
    // failing the laser check never occupy a stage; out-of-window ones skip stage 2.
    always_comb begin
        out_adv       = !m_valid_reg || m_ready;
        p2_ready      = !p2_valid_reg || out_adv;
        s_ready       = !p1_valid_reg || p2_ready;
        p1_valid_next = s_ready ? tbl_rd_en : p1_valid_reg;
        p2_valid_next = p2_ready ? (p1_valid_reg && p1_keep) : p2_valid_reg;
        m_valid_next  = out_adv ? p2_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_laser_index     = m_laser_reg;
    assign m_range           = m_range_reg;
    assign m_heading         = m_heading_reg;
    assign m_pitch           = m_pitch_reg;
    assign m_point_intensity = m_inten_reg;

    // A calibration load never enters the return pipeline.
    `LRP_ASSERT(a_load_no_stage, aclk, aresetn, (accept && !is_return) |=> !p1_valid_reg)
    // A return outside the range window is dropped before stage 2.
    `LRP_ASSERT(a_drop_out_of_window, aclk, aresetn, (p1_valid_reg && p2_ready && !p1_keep) |=> !p2_valid_reg)
    // A new result only appears when stage 2 held a kept return.
    `LRP_ASSERT(a_result_from_stage2, aclk, aresetn, $rose(m_valid_reg) |-> $past(p2_valid_reg))
    // The reduced heading lies in the half-open turn around zero.
    `LRP_ASSERT(a_heading_wrapped, aclk, aresetn, p2_valid_reg |-> ((p2_heading <= HEAD_MAX) && (p2_heading >= HEAD_MIN)))

endmodule

`default_nettype wire

// ===== src/lrp_cal_tables.sv =====
// Per-laser calibration memory: one write port and one registered read port.
// Depends on lrp_pkg for the entry type.
`default_nettype none

module lrp_cal_tables #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire lrp_pkg::cal_entry_t  wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    output lrp_pkg::cal_entry_t       rd_data
);
    import lrp_pkg::*;

    cal_entry_t mem [DEPTH];
    cal_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/lrp_quot_est.sv =====
// Heading reduction, first half: offsets the heading difference to a
// non-negative value and estimates its quotient by one turn. Uses lrp_pkg.
`default_nettype none

module lrp_quot_est #(
    parameter int STEPS_PER_TURN = 36000
) (
    input  wire logic signed [lrp_pkg::DIFF_W-1:0] diff,
    output logic [lrp_pkg::DIFF_W-1:0]             d_off,
    output logic [lrp_pkg::DIFF_W-1:0]             q_est
);
    import lrp_pkg::*;

    // Smallest whole number of turns that lifts the most negative difference
    // (-98303) to zero or above.
    localparam int OFFSET = ((98303 + STEPS_PER_TURN - 1) / STEPS_PER_TURN) * STEPS_PER_TURN;
    // Reciprocal of one turn with DIFF_W fraction bits. The estimate is at most
    // one below the true quotient because d_off stays below 2**DIFF_W.
    localparam int RECIP = (2 ** DIFF_W) / STEPS_PER_TURN;

    logic [2*DIFF_W-1:0] prod;

    always_comb begin
        d_off = DIFF_W'(int'(diff) + OFFSET);
        prod  = d_off * DIFF_W'(RECIP);
        q_est = prod[2*DIFF_W-1:DIFF_W];
    end

endmodule

`default_nettype wire

// ===== src/lrp_wrap_fix.sv =====
// Heading reduction, second half: remainder from the quotient estimate, one
// correction, then the wrap into the half-open turn centered on zero. Uses lrp_pkg.
`default_nettype none

module lrp_wrap_fix #(
    parameter int STEPS_PER_TURN = 36000
) (
    input  wire logic [lrp_pkg::DIFF_W-1:0]  d_off,
    input  wire logic [lrp_pkg::DIFF_W-1:0]  q_est,
    output logic signed [lrp_pkg::DIFF_W-1:0] heading
);
    import lrp_pkg::*;

    localparam logic [DIFF_W-1:0] TURN = DIFF_W'(STEPS_PER_TURN);

    logic [2*DIFF_W-1:0] prod;
    logic [DIFF_W-1:0]   rem_raw;
    logic [DIFF_W-1:0]   rem;

    always_comb begin
        prod    = q_est * TURN;
        // True remainder before correction lies in [0, 2 turns).
        rem_raw = d_off - prod[DIFF_W-1:0];
        rem     = (rem_raw >= TURN) ? (rem_raw - TURN) : rem_raw;
        // Upper half of the turn folds down to negative headings.
        if ({rem, 1'b0} > {1'b0, TURN}) begin
            heading = $signed(rem - TURN);
        end else begin
            heading = $signed(rem);
        end
    end

endmodule

`default_nettype wire
